// ----- rtl/core/sssc_pkg.sv -----
package sssc_pkg;

  // Default number of scanned digits and the fixed width of a number word.
  localparam int unsigned DigitsDefault = 8;
  localparam int unsigned NumW          = 32;
  localparam int unsigned RadixW        = 5;
  localparam int unsigned NibbleW       = 4;

  // Smallest and largest radix the splitter honors.
  localparam logic [RadixW-1:0] RadixMin = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax = RadixW'(16);
  localparam logic [RadixW-1:0] RadixRst = RadixW'(10);

  typedef enum logic [1:0] {
    FuncTick = 2'd0,
    FuncShow = 2'd1,
    FuncSet  = 2'd2
  } sssc_func_e;

  typedef enum logic [1:0] {
    CfgEnable = 2'd0,
    CfgLed    = 2'd1,
    CfgRadix  = 2'd2
  } sssc_cfg_e;

  typedef enum logic {
    SplitIdle,
    SplitDivide
  } sssc_split_e;

  // Status from the digit splitter toward the top level.
  typedef struct packed {
    logic               busy;
    logic               digit_valid;
    logic [NibbleW-1:0] digit_value;
  } sssc_split_t;

  // Segment font for hexadecimal digits 0 through F.
  function automatic logic [7:0] seg_font(input logic [NibbleW-1:0] nib);
    logic [7:0] seg;
    unique case (nib)
      4'h0: seg = 8'h3f;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5b;
      4'h3: seg = 8'h4f;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6d;
      4'h6: seg = 8'h7d;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7f;
      4'h9: seg = 8'h6f;
      4'ha: seg = 8'h77;
      4'hb: seg = 8'h7c;
      4'hc: seg = 8'h39;
      4'hd: seg = 8'h5e;
      4'he: seg = 8'h79;
      4'hf: seg = 8'h71;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ----- rtl/core/sssc_digit_splitter.sv -----
// Bit-serial restoring divider that peels DIGITS digits off a number,
// least significant first, one quotient bit per cycle.
module sssc_digit_splitter #(
  parameter int unsigned DIGITS = sssc_pkg::DigitsDefault,
  localparam int unsigned IdxW  = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [sssc_pkg::NumW-1:0]         number_i,
  input  logic [sssc_pkg::RadixW-1:0]       radix_i,
  output sssc_pkg::sssc_split_t             status_o,
  output logic [IdxW-1:0]                   digit_idx_o
);

  localparam int unsigned BitW = $clog2(sssc_pkg::NumW);
  localparam logic [BitW-1:0] BitLast  = BitW'(sssc_pkg::NumW - 1);
  localparam logic [IdxW-1:0] DigitLast = IdxW'(DIGITS - 1);

  sssc_pkg::sssc_split_e state_q, state_d;
  logic [sssc_pkg::NumW-1:0]    num_q, num_d;
  logic [sssc_pkg::NibbleW-1:0] rem_q, rem_d;
  logic [BitW-1:0]              bit_q, bit_d;
  logic [IdxW-1:0]              dig_q, dig_d;

  logic [sssc_pkg::RadixW-1:0]  radix_eff;
  logic [sssc_pkg::RadixW-1:0]  shifted;
  logic [sssc_pkg::RadixW:0]    diff;
  logic                         fits;
  logic [sssc_pkg::NibbleW-1:0] rem_next;
  logic                         digit_end;

  always_comb begin
    if (radix_i < sssc_pkg::RadixMin) begin
      radix_eff = sssc_pkg::RadixMin;
    end else if (radix_i > sssc_pkg::RadixMax) begin
      radix_eff = sssc_pkg::RadixMax;
    end else begin
      radix_eff = radix_i;
    end
  end

  // One restoring step: bring in the next dividend bit and try to subtract.
  assign shifted   = {rem_q, num_q[sssc_pkg::NumW-1]};
  assign diff      = {1'b0, shifted} - {1'b0, radix_eff};
  assign fits      = ~diff[sssc_pkg::RadixW];
  assign rem_next  = fits ? diff[sssc_pkg::NibbleW-1:0] : shifted[sssc_pkg::NibbleW-1:0];
  assign digit_end = (bit_q == BitLast);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sssc_pkg::SplitIdle: begin
        if (start_i) begin
          state_d = sssc_pkg::SplitDivide;
        end
      end
      sssc_pkg::SplitDivide: begin
        if (digit_end && (dig_q == DigitLast)) begin
          state_d = sssc_pkg::SplitIdle;
        end
      end
      default: state_d = sssc_pkg::SplitIdle;
    endcase
  end

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    bit_d = bit_q;
    dig_d = dig_q;
    status_o = '0;
    unique case (state_q)
      sssc_pkg::SplitIdle: begin
        if (start_i) begin
          num_d = number_i;
          rem_d = '0;
          bit_d = '0;
          dig_d = '0;
        end
      end
      sssc_pkg::SplitDivide: begin
        status_o.busy = 1'b1;
        num_d = {num_q[sssc_pkg::NumW-2:0], fits};
        rem_d = rem_next;
        bit_d = bit_q + BitW'(1);
        if (digit_end) begin
          status_o.digit_valid = 1'b1;
          status_o.digit_value = rem_next;
          rem_d = '0;
          dig_d = dig_q + IdxW'(1);
        end
      end
      default: begin
        status_o = '0;
      end
    endcase
  end

  assign digit_idx_o = dig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sssc_pkg::SplitIdle;
      bit_q   <= '0;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      dig_q   <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

endmodule

// ----- rtl/core/seven_segment_scan_controller.sv -----
// Scan controller for a multiplexed seven-segment display with DIGITS digits
// and one LED bank. Each input word carries a function code: a tick word
// produces one output word for the next scan slot (DIGITS digit slots, then
// the LED slot, then around again); a show-number word converts the 32-bit
// number into DIGITS digits of the configured radix and stores their segment
// patterns; a set-pattern word stores a raw pattern into one digit. A
// show-number word keeps the input stalled while the conversion runs on
// one bit-serial restoring divider that retires one quotient bit per
// cycle, running a full 32-bit division for each digit. Tick output is
// held in an output register, so a new input word is taken in the same
// cycle the waiting output word leaves. Configuration writes go straight
// to their registers and are meant to happen while the block is idle.
module seven_segment_scan_controller #(
  parameter int unsigned DIGITS = sssc_pkg::DigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,

  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] number_i,
  input  logic [2:0]  digit_index_i,
  input  logic [7:0]  pattern_i,

  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  port_data_o,
  output logic [2:0]  digit_select_o,
  output logic        led_phase_o
);

  localparam int unsigned IdxW  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned SlotW = $clog2(DIGITS + 1);
  // Wide enough to compare any digit index or slot against DIGITS for DIGITS up to 63.
  localparam int unsigned CmpW  = 6;

  // Configuration registers.
  logic [7:0]                  enable_q;
  logic [7:0]                  led_q;
  logic [sssc_pkg::RadixW-1:0] radix_q;

  // Digit store and scan position.
  logic [7:0]       store_q [DIGITS];
  logic [SlotW-1:0] slot_q;

  // Output register.
  logic       out_valid_q;
  logic [7:0] port_data_q;
  logic [2:0] digit_select_q;
  logic       led_phase_q;

  sssc_pkg::sssc_split_t split;
  logic [IdxW-1:0]       split_idx;

  logic            in_accept;
  logic            tick_accept;
  logic            show_accept;
  logic            set_accept;
  logic [CmpW-1:0] set_idx_ext;
  logic [CmpW-1:0] slot_ext;
  logic [CmpW-1:0] sel_ext;
  logic            led_slot;
  logic            slot_on;
  logic [7:0]      slot_data;

  // The input stalls during a conversion and whenever a waiting output word
  // cannot leave.
  assign in_stall_o  = split.busy | (out_valid_q & out_stall_i);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign tick_accept = in_accept & (func_i == sssc_pkg::FuncTick);
  assign show_accept = in_accept & (func_i == sssc_pkg::FuncShow);
  assign set_accept  = in_accept & (func_i == sssc_pkg::FuncSet) &
                       (set_idx_ext < CmpW'(DIGITS));

  assign set_idx_ext = CmpW'(digit_index_i);

  sssc_digit_splitter #(
    .DIGITS (DIGITS)
  ) u_splitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (show_accept),
    .number_i    (number_i),
    .radix_i     (radix_q),
    .status_o    (split),
    .digit_idx_o (split_idx)
  );

  // Slot decode. Digits at or above eight have no enable bit and stay dark.
  assign slot_ext = CmpW'(slot_q);
  assign led_slot = (slot_ext >= CmpW'(DIGITS));
  assign slot_on  = (slot_ext < CmpW'(8)) & enable_q[slot_ext[2:0]];
  assign sel_ext  = CmpW'(DIGITS - 1) - slot_ext;

  always_comb begin
    if (led_slot) begin
      slot_data = led_q;
    end else if (slot_on) begin
      slot_data = store_q[slot_q[IdxW-1:0]];
    end else begin
      slot_data = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      led_q    <= '0;
      radix_q  <= sssc_pkg::RadixRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sssc_pkg::CfgEnable: enable_q <= cfg_data_i;
        sssc_pkg::CfgLed:    led_q    <= cfg_data_i;
        sssc_pkg::CfgRadix:  radix_q  <= cfg_data_i[sssc_pkg::RadixW-1:0];
        default: ;
      endcase
    end
  end

  // The store is cleared by reset; conversion digits and raw patterns never
  // arrive in the same cycle because the input stalls during a conversion.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) begin
        store_q[i] <= 8'h00;
      end
    end else if (split.digit_valid) begin
      store_q[split_idx] <= sssc_pkg::seg_font(split.digit_value);
    end else if (set_accept) begin
      store_q[set_idx_ext[IdxW-1:0]] <= pattern_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_accept) begin
        slot_q      <= led_slot ? '0 : slot_q + SlotW'(1);
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_accept) begin
      port_data_q    <= slot_data;
      digit_select_q <= led_slot ? 3'd0 : sel_ext[2:0];
      led_phase_q    <= led_slot;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign port_data_o    = port_data_q;
  assign digit_select_o = digit_select_q;
  assign led_phase_o    = led_phase_q;

endmodule

// ----- rtl/core/sssc_checker.sv -----
// Port-level checks for the scan controller.
module sssc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  func_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  digit_select_o,
  input logic        led_phase_o
);

  // A stalled output word is not withdrawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // The LED slot always reports digit select zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && led_phase_o |-> digit_select_o == 3'd0)
    else $error("LED slot with nonzero digit select");

  // A new output word only follows an accepted tick word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o &&
                                 func_i == sssc_pkg::FuncTick))
    else $error("output word without a tick");

  // A show-number word starts a conversion that stalls the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == sssc_pkg::FuncShow |=> in_stall_o)
    else $error("conversion did not stall the input");

endmodule

bind seven_segment_scan_controller sssc_checker u_sssc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .func_i         (func_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .digit_select_o (digit_select_o),
  .led_phase_o    (led_phase_o)
);
